// ===== rtl/sspg_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper step pulse generator package
// Shared constants, phase codes, register indexes and channel payload types.
// ----------------------------------------------------------------------------
package sspg_pkg;

   localparam int PERIOD_BITS = 40;
   localparam int PULSE_TICKS = 150;
   localparam int COUNT_BITS  = 64;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 1;

   localparam logic [PERIOD_BITS-1:0] PULSE_TICKS_VAL = PERIOD_BITS'(PULSE_TICKS);

   typedef logic [PERIOD_BITS-1:0] period_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP_POL = 1'b0,
      CSR_DIR_POL  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PULSE = 3'b010,
      PH_GAP   = 3'b100
   } phase_type;

   typedef struct packed {
      period_type period_whole;
      period_type period_frac_num;
      period_type period_frac_den;
      logic       want_forward;
      logic       run;
      logic       driver_on;
      logic       stop_now;
      logic       clear_count;
   } req_type;

   typedef struct packed {
      logic                           step_level;
      logic                           dir_level;
      logic                           enable_level;
      logic                           step_started;
      logic                           stepping;
      logic signed [COUNT_BITS-1:0]   step_count;
   } rsp_type;

endpackage

// ===== rtl/stepper_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// Stepper step pulse generator
// STEP/DIR/ENABLE pulse train with a fractional period, one request per tick unless rsp_ready stalls.
// ----------------------------------------------------------------------------
// A request is held in the input register; its result is then written to the
//   output register when that register is empty or being read, and rsp_valid
//   rises as it is written. Throughput: one request per cycle unless rsp_ready
//   stalls, set by the single state update between input and output register.
// Reset clears the valid flags and the stepping state and sets the two
//   configuration registers (STEP active low, DIR not inverted).
module stepper_step_pulse_generator
   import sspg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       fire;

   logic       sal_ff;
   logic       inv_ff;

   phase_type  phase_ff, phase_in;
   period_type cd_ff, cd_in;
   period_type acc_ff, acc_in;
   period_type aw_ff, aw_in;
   period_type an_ff, an_in;
   period_type ad_ff, ad_in;
   period_type cur_ff, cur_in;
   logic       mf_ff, mf_in;
   logic [COUNT_BITS-1:0] steps_ff, steps_in;

   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic             rate_change;
   period_type       sel_whole, sel_num, sel_den, acc_base;
   logic [PERIOD_BITS:0] sum_full;
   period_type       sum_wrap, sum_sub, sum_fin, ticks;
   logic             extra_tick;
   logic             try_start;
   logic             started;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // rate change detect and Bresenham accumulator
   always_comb begin
      rate_change = (aw_ff != in_data_ff.period_whole) ||
                    (an_ff != in_data_ff.period_frac_num) ||
                    (ad_ff != in_data_ff.period_frac_den);
      sel_whole = rate_change ? in_data_ff.period_whole    : aw_ff;
      sel_num   = rate_change ? in_data_ff.period_frac_num : an_ff;
      sel_den   = rate_change ? in_data_ff.period_frac_den : ad_ff;
      acc_base  = rate_change ? '0 : acc_ff;
      sum_full  = {1'b0, acc_base} + {1'b0, sel_num};
      sum_wrap  = sum_full[PERIOD_BITS-1:0];
      sum_sub   = sum_wrap - sel_den;
      extra_tick = sum_full[PERIOD_BITS] || (sum_wrap >= sel_den);
      sum_fin   = extra_tick ? sum_sub : sum_wrap;
      if (extra_tick && (sel_whole != '1)) begin
         ticks = sel_whole + PERIOD_BITS'(1);
      end else begin
         ticks = sel_whole;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      cd_in     = cd_ff;
      acc_in    = acc_ff;
      aw_in     = aw_ff;
      an_in     = an_ff;
      ad_in     = ad_ff;
      cur_in    = cur_ff;
      mf_in     = mf_ff;
      steps_in  = in_data_ff.clear_count ? '0 : steps_ff;
      try_start = 1'b0;
      started   = 1'b0;

      if (in_data_ff.stop_now) begin
         phase_in = PH_IDLE;
         cd_in    = '0;
         aw_in    = '0;
         an_in    = '0;
         ad_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_PULSE: begin
               if (cd_ff <= PERIOD_BITS'(1)) begin
                  mf_in    = in_data_ff.want_forward;
                  phase_in = PH_GAP;
                  cd_in    = (cur_ff > PULSE_TICKS_VAL) ? cur_ff - PULSE_TICKS_VAL
                                                        : PERIOD_BITS'(1);
               end else begin
                  cd_in = cd_ff - PERIOD_BITS'(1);
               end
            end
            PH_GAP: begin
               if (cd_ff <= PERIOD_BITS'(1)) begin
                  cd_in     = '0;
                  try_start = 1'b1;
               end else begin
                  cd_in = cd_ff - PERIOD_BITS'(1);
               end
            end
            default: begin
               mf_in     = in_data_ff.want_forward;
               try_start = 1'b1;
            end
         endcase
      end

      if (try_start) begin
         if (!in_data_ff.run || !in_data_ff.driver_on) begin
            phase_in = PH_IDLE;
         end else begin
            aw_in  = sel_whole;
            an_in  = sel_num;
            ad_in  = sel_den;
            acc_in = acc_base;
            if (sel_whole == '0) begin
               phase_in = PH_IDLE;
            end else begin
               acc_in   = sum_fin;
               cur_in   = ticks;
               steps_in = mf_in ? steps_in + COUNT_BITS'(1) : steps_in - COUNT_BITS'(1);
               phase_in = PH_PULSE;
               cd_in    = PULSE_TICKS_VAL;
               started  = 1'b1;
            end
         end
      end

      if (phase_in == PH_IDLE) begin
         mf_in = in_data_ff.want_forward;
      end

      rsp_data_in.step_level   = (phase_in == PH_PULSE) ? ~sal_ff : sal_ff;
      rsp_data_in.dir_level    = mf_in ^ inv_ff;
      rsp_data_in.enable_level = ~in_data_ff.driver_on;
      rsp_data_in.step_started = started;
      rsp_data_in.stepping     = (phase_in != PH_IDLE);
      rsp_data_in.step_count   = steps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sal_ff       <= 1'b1;
         inv_ff       <= 1'b0;
         phase_ff     <= PH_IDLE;
         cd_ff        <= '0;
         acc_ff       <= '0;
         aw_ff        <= '0;
         an_ff        <= '0;
         ad_ff        <= '0;
         cur_ff       <= '0;
         mf_ff        <= 1'b1;
         steps_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_STEP_POL: sal_ff <= csr_wdata[0];
               CSR_DIR_POL:  inv_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (fire) begin
            phase_ff <= phase_in;
            cd_ff    <= cd_in;
            acc_ff   <= acc_in;
            aw_ff    <= aw_in;
            an_ff    <= an_in;
            ad_ff    <= ad_in;
            cur_ff   <= cur_in;
            mf_ff    <= mf_in;
            steps_ff <= steps_in;
         end
      end
   end

   // hold payload registers without reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register lost its one-hot code");

   a_gap_countdown: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GAP) |-> (cd_ff != '0))
      else $error("gap phase with an expired countdown");

   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && in_data_ff.stop_now) |=> (phase_ff == PH_IDLE && aw_ff == '0))
      else $error("stop request did not return to idle");

   a_start_pulse: assert property (@(posedge clock) disable iff (reset)
      (fire && started) |=>
         (phase_ff == PH_PULSE && cd_ff == PULSE_TICKS_VAL && rsp_data.stepping))
      else $error("started step did not enter the pulse phase");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && !started && !in_data_ff.clear_count) |=> $stable(steps_ff))
      else $error("step count moved without a step");

endmodule
